/* rtl/lkv_pkg.sv */
`timescale 1ns / 1ps

package lkv_pkg;

   // Cache geometry.
   localparam int MAX_ENTRIES = 16;
   localparam int SLOT_BITS   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OCC_BITS    = $clog2(MAX_ENTRIES + 1);

   // Field widths of the request, response and capacity register.
   localparam int KEY_W = 32;
   localparam int DATA_W = 32;
   localparam int CAP_BITS = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

   // Operation codes.
   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_MATCH = 3'b010,
      ST_REPLY = 3'b100
   } state_type;

   // Outcome of one lookup in the tag array.
   typedef struct packed {
      logic                 hit;
      logic                 evict;
      logic [SLOT_BITS-1:0] slot;
   } lookup_type;

endpackage

/* rtl/lru_key_value_cache_core.sv */
`timescale 1ns / 1ps

// Fully associative key/value cache with least-recently-used replacement.
// Requests arrive on the req_ channel (opcode, key, write_value) and each
// word gives exactly one response word on the rsp_ channel (found,
// read_value, evicted). A get returns the stored value on a hit and all
// ones on a miss; a set updates or inserts and returns zero, flagging an
// eviction when the cache was full. The csr_ channel writes the capacity
// (0 acts as 1, values above 16 act as 16); write it only while idle.
// Each request is captured into the request registers, compared and
// updated in the match state, which also reads the data memory into its
// registered read port, and answered in the reply state. The next request
// is taken in the same cycle the previous response is loaded into the
// output register. If rsp_stall holds the output, the core finishes at
// most one more request and then raises req_stall.
// Reset (synchronous, active high) empties the cache, sets the capacity
// to 16 and clears all handshake state; no clearing pass is needed.
module lru_key_value_cache_core import lkv_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_opcode,
   input  logic signed [KEY_W-1:0]  req_key,
   input  logic signed [DATA_W-1:0] req_write_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_found,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic                     rsp_evicted,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CAP_BITS-1:0]      csr_capacity
);

   state_type state_ff, state_in;
   logic [CAP_BITS-1:0] cap_ff, cap_in;
   logic [CAP_BITS-1:0] eff_cap;

   logic              op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [DATA_W-1:0] wval_ff, wval_in;
   logic              hit_ff, hit_in;
   logic              evict_ff, evict_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_evict_ff, rsp_evict_in;

   logic              accept;
   logic              rsp_free;
   logic              in_match;
   lookup_type        lookup;
   logic [DATA_W-1:0] ram_rd_data;

   // Capacity register and its effective value.
   assign csr_ready = 1'b1;
   assign cap_in = (csr_valid && csr_ready) ? csr_capacity : cap_ff;
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CAP_BITS'(1);
      end else if (cap_ff > CAP_BITS'(MAX_ENTRIES)) begin
         eff_cap = CAP_BITS'(MAX_ENTRIES);
      end else begin
         eff_cap = cap_ff;
      end
   end

   // Handshake: a new word enters when idle or when the pending response
   // moves into the output register.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_REPLY) && rsp_free));
   assign accept    = req_valid && !req_stall;
   assign in_match  = (state_ff == ST_MATCH);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MATCH;
         end
         ST_MATCH: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (rsp_free) state_in = accept ? ST_MATCH : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Request word capture and lookup outcome.
   assign op_in    = accept ? req_opcode : op_ff;
   assign key_in   = accept ? req_key : key_ff;
   assign wval_in  = accept ? req_write_value : wval_ff;
   assign hit_in   = in_match ? lookup.hit : hit_ff;
   assign evict_in = in_match ? lookup.evict : evict_ff;

   lkv_tags u_tags (
      .clock   (clock),
      .reset   (reset),
      .upd_en  (in_match),
      .op      (op_ff),
      .key     (key_ff),
      .eff_cap (eff_cap),
      .result  (lookup)
   );

   // Data memory: a set writes its slot, a get reads the hit slot.
   lkv_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ENTRIES)
   ) u_data (
      .clock   (clock),
      .wr_en   (in_match && (op_ff == OP_SET)),
      .wr_addr (lookup.slot),
      .wr_data (wval_ff),
      .rd_en   (in_match && (op_ff == OP_GET)),
      .rd_addr (lookup.slot),
      .rd_data (ram_rd_data)
   );

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_evict_in = rsp_evict_ff;
      if ((state_ff == ST_REPLY) && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = hit_ff;
         rsp_evict_in = evict_ff;
         if (op_ff == OP_SET) begin
            rsp_data_in = '0;
         end else if (hit_ff) begin
            rsp_data_in = ram_rd_data;
         end else begin
            rsp_data_in = '1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      wval_ff      <= wval_in;
      hit_ff       <= hit_in;
      evict_ff     <= evict_in;
      rsp_found_ff <= rsp_found_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_evict_ff <= rsp_evict_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_data_ff;
   assign rsp_evicted    = rsp_evict_ff;

endmodule

/* rtl/lkv_ram.sv */
`timescale 1ns / 1ps

module lkv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lkv_tags.sv */
`timescale 1ns / 1ps

module lkv_tags import lkv_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                upd_en,
   input  logic                op,
   input  logic [KEY_W-1:0]    key,
   input  logic [CAP_BITS-1:0] eff_cap,
   output lookup_type          result
);

   // Each slot holds a key, a valid bit and its position in recency order
   // (zero is the most recent). Values live in the data memory by slot.
   logic [KEY_W-1:0]     key_ff  [MAX_ENTRIES];
   logic [KEY_W-1:0]     key_in  [MAX_ENTRIES];
   logic [SLOT_BITS-1:0] rank_ff [MAX_ENTRIES];
   logic [SLOT_BITS-1:0] rank_in [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_ff;
   logic [MAX_ENTRIES-1:0] valid_in;
   logic [OCC_BITS-1:0]  occ_ff;
   logic [OCC_BITS-1:0]  occ_in;

   logic [MAX_ENTRIES-1:0] hit_vec;
   logic [MAX_ENTRIES-1:0] keep;
   logic                   hit;
   logic                   evict;
   logic [SLOT_BITS-1:0]   hit_slot;
   logic [SLOT_BITS-1:0]   hit_rank;
   logic [SLOT_BITS-1:0]   free_slot;
   logic [CAP_BITS-1:0]    cap_last;

   // Parallel key compare, and the slots that survive an eviction.
   always_comb begin
      hit_slot  = '0;
      free_slot = '0;
      cap_last  = eff_cap - CAP_BITS'(1);
      for (int p = 0; p < MAX_ENTRIES; p++) begin
         hit_vec[p] = valid_ff[p] && (key_ff[p] == key);
      end
      hit   = |hit_vec;
      evict = (op == OP_SET) && !hit && (CAP_BITS'(occ_ff) >= eff_cap);
      for (int p = MAX_ENTRIES - 1; p >= 0; p--) begin
         if (hit_vec[p]) begin
            hit_slot = SLOT_BITS'(p);
         end
      end
      hit_rank = rank_ff[hit_slot];
      for (int p = 0; p < MAX_ENTRIES; p++) begin
         keep[p] = valid_ff[p] && !(evict && (CAP_BITS'(rank_ff[p]) >= cap_last));
      end
      // The lowest free slot takes a newly inserted key.
      for (int p = MAX_ENTRIES - 1; p >= 0; p--) begin
         if (!keep[p]) begin
            free_slot = SLOT_BITS'(p);
         end
      end
      result.hit   = hit;
      result.evict = evict;
      result.slot  = hit ? hit_slot : free_slot;
   end

   // Recency update: a hit moves its slot to the front, an insert pushes
   // every surviving slot back by one.
   always_comb begin
      key_in   = key_ff;
      rank_in  = rank_ff;
      valid_in = valid_ff;
      occ_in   = occ_ff;
      if (upd_en) begin
         if (hit) begin
            for (int p = 0; p < MAX_ENTRIES; p++) begin
               if (SLOT_BITS'(p) == hit_slot) begin
                  rank_in[p] = '0;
               end else if (valid_ff[p] && (rank_ff[p] < hit_rank)) begin
                  rank_in[p] = rank_ff[p] + SLOT_BITS'(1);
               end
            end
         end else if (op == OP_SET) begin
            for (int p = 0; p < MAX_ENTRIES; p++) begin
               valid_in[p] = keep[p];
               if (keep[p]) begin
                  rank_in[p] = rank_ff[p] + SLOT_BITS'(1);
               end
            end
            valid_in[free_slot] = 1'b1;
            rank_in[free_slot]  = '0;
            key_in[free_slot]   = key;
            occ_in = (evict ? OCC_BITS'(cap_last) : occ_ff) + OCC_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      rank_ff <= rank_in;
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
      end
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import lkv_pkg::*;

   localparam int POOL_SIZE       = 20;
   localparam int ITEMS_PER_PHASE = 90;
   localparam int NUM_PHASES      = 8;
   localparam int HOLD_CYCLES     = 200;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int MAX_REPORTS     = 100;

   typedef struct packed {
      logic              op;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] wdata;
   } cache_req_type;

   typedef struct packed {
      logic              found;
      logic [DATA_W-1:0] read_value;
      logic              evicted;
   } cache_rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
   } cache_line_type;

   // Block inputs start at known values.
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_opcode = OP_GET;
   logic signed [KEY_W-1:0]  req_key = '0;
   logic signed [DATA_W-1:0] req_write_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_found;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic                     rsp_evicted;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CAP_BITS-1:0]      csr_capacity = CAP_RESET;

   // Stimulus and expectation stores.
   cache_req_type  pending_reqs[$];
   cache_rsp_type  expected_rsps[$];
   cache_line_type lru_lines[$];   // index 0 holds the most recent line
   logic [CAP_BITS-1:0] cap_reg = CAP_RESET;
   logic [KEY_W-1:0]    key_pool[POOL_SIZE];

   int send_idle_pct = 0;
   int stall_pct = 0;
   logic hold_armed = 1'b0;
   logic hold_done;
   int hold_left;
   int quiet_cycles = 0;

   int mismatches = 0;
   int rsps_checked = 0;
   int n_gets = 0;
   int n_sets = 0;
   int n_hits = 0;
   int n_evictions = 0;
   int csr_writes = 0;

   lru_key_value_cache_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_key         (req_key),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_capacity    (csr_capacity)
   );

   always #5 clock = ~clock;

   // Capacity as the cache applies it: zero acts as one, large values clamp.
   function automatic int effective_capacity(input logic [CAP_BITS-1:0] cap);
      if (cap == 0) return 1;
      if (cap > MAX_ENTRIES) return MAX_ENTRIES;
      return int'(cap);
   endfunction

   // Apply one accepted request to the recency list and queue its response.
   function automatic void predict_lookup(input logic op, input logic [KEY_W-1:0] key,
                                          input logic [DATA_W-1:0] wdata);
      cache_rsp_type  r;
      cache_line_type line;
      int             hit_pos;
      int             cap;
      hit_pos = -1;
      foreach (lru_lines[i])
         if (hit_pos < 0 && lru_lines[i].key == key) hit_pos = i;
      r.found = (hit_pos >= 0);
      r.read_value = '0;
      r.evicted = 1'b0;
      if (op == OP_GET) n_gets++;
      else n_sets++;
      if (hit_pos >= 0) begin
         n_hits++;
         line = lru_lines[hit_pos];
         lru_lines.delete(hit_pos);
         if (op == OP_GET) r.read_value = line.data;
         else line.data = wdata;
         lru_lines.push_front(line);
      end else if (op == OP_GET) begin
         r.read_value = '1;
      end else begin
         // A miss on a full cache drops everything from the last kept position on.
         cap = effective_capacity(cap_reg);
         if (lru_lines.size() >= cap) begin
            while (lru_lines.size() > cap - 1) void'(lru_lines.pop_back());
            r.evicted = 1'b1;
            n_evictions++;
         end
         line.key = key;
         line.data = wdata;
         lru_lines.push_front(line);
      end
      expected_rsps.push_back(r);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < MAX_REPORTS)
         $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic queue_req(input logic op, input logic [KEY_W-1:0] key,
                            input logic [DATA_W-1:0] wdata);
      cache_req_type r;
      r.op = op;
      r.key = key;
      r.wdata = wdata;
      pending_reqs.push_back(r);
   endtask

   // Return once every queued word has been sent and answered.
   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_capacity <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cap_reg = value;
      csr_writes++;
   endtask

   function automatic cache_req_type random_req(input int span);
      cache_req_type r;
      int pick;
      r.op = ($urandom_range(99) < 55) ? OP_GET : OP_SET;
      pick = $urandom_range(99);
      if (pick < 75) r.key = key_pool[$urandom_range(span - 1)];
      else if (pick < 85) r.key = key_pool[0] ^ (32'd1 << $urandom_range(KEY_W - 1));
      else r.key = $urandom;
      pick = $urandom_range(19);
      if (pick == 0) r.wdata = '1;
      else if (pick == 1) r.wdata = '0;
      else if (pick == 2) r.wdata = {1'b1, {(DATA_W - 1){1'b0}}};
      else r.wdata = $urandom;
      return r;
   endfunction

   // Request driver: holds a stalled word, otherwise offers the next one.
   always @(posedge clock) begin : drive_requests
      cache_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predict_lookup(req_opcode, req_key, req_write_value);
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_opcode <= nxt.op;
               req_key <= nxt.key;
               req_write_value <= nxt.wdata;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response stall: random stalls plus one long hold-off when armed.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (hold_armed && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end
         rsp_stall <= (hold_armed && !hold_done) || (hold_left > 1) ||
                      ($urandom_range(99) < stall_pct);
      end
   end

   // Response monitor: compares each accepted word with the oldest expectation.
   always @(posedge clock) begin : check_responses
      cache_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsps_checked++;
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response word", rsp_read_value, '0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_found !== want.found)
               report_mismatch("found", rsp_found, want.found);
            if (rsp_read_value !== want.read_value)
               report_mismatch("read_value", rsp_read_value, want.read_value);
            if (rsp_evicted !== want.evicted)
               report_mismatch("evicted", rsp_evicted, want.evicted);
         end
      end
   end

   // Watchdog: count cycles in which no channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL lru_key_value_cache_core");
      $finish;
   end

   // Test sequence.
   initial begin : stimulus
      logic [CAP_BITS-1:0] phase_caps[NUM_PHASES];
      int span;
      phase_caps = '{5'd16, 5'd31, 5'd1, 5'd5, 5'd17, 5'd0, 5'd8, 5'd16};
      phase_caps[NUM_PHASES - 1] = CAP_BITS'($urandom_range(31));
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[1] = {1'b1, {(KEY_W - 1){1'b0}}};
      key_pool[2] = {1'b0, {(KEY_W - 1){1'b1}}};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes at the reset capacity.
      queue_req(OP_GET, 32'h0000_0000, 32'h1234_5678);
      queue_req(OP_SET, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_req(OP_SET, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_req(OP_SET, 32'h0000_0000, 32'h0000_0000);
      queue_req(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(OP_GET, 32'h8000_0000, 32'h0000_0000);
      queue_req(OP_GET, 32'h8000_0001, 32'h0000_0000);
      queue_req(OP_SET, 32'h0000_0000, 32'h0000_3039);
      queue_req(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      queue_req(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      wait_idle();

      // Capacity lowered below occupancy: lookups still see every line,
      // and the next missing set trims the list in one step.
      write_capacity(5'd2);
      queue_req(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      queue_req(OP_SET, 32'h0000_0005, 32'hAAAA_5555);
      queue_req(OP_GET, 32'h0000_0000, 32'h0000_0000);
      queue_req(OP_SET, 32'h0000_0005, 32'h0000_0001);
      queue_req(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      wait_idle();

      // A capacity of zero behaves as one.
      write_capacity(5'd0);
      queue_req(OP_SET, 32'h0000_004D, 32'h5555_AAAA);
      queue_req(OP_GET, 32'h0000_004D, 32'h0000_0000);
      queue_req(OP_SET, 32'h0000_004E, 32'h0F0F_0F0F);
      queue_req(OP_GET, 32'h0000_004D, 32'h0000_0000);
      wait_idle();

      // Random phases: each one sets a capacity and an idling pattern.
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_capacity(phase_caps[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 48; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 48; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
         endcase
         span = effective_capacity(phase_caps[p]) + 3;
         if (span > POOL_SIZE) span = POOL_SIZE;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) pending_reqs.push_back(random_req(span));
         // Let the cache back up behind a long receiver hold-off once.
         if (p == 4) hold_armed <= 1'b1;
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run covered %0d gets and %0d sets with %0d hits and %0d evictions,",
               n_gets, n_sets, n_hits, n_evictions);
      $display("%0d capacity writes, %0d response words checked, %0d mismatches.",
               csr_writes, rsps_checked, mismatches);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("PASS lru_key_value_cache_core");
      else
         $display("FAIL lru_key_value_cache_core");
      $finish;
   end

endmodule

/* files.f */
rtl/lkv_pkg.sv
rtl/lkv_ram.sv
rtl/lkv_tags.sv
rtl/lru_key_value_cache_core.sv
test/tb_top.sv
